[hw/rtl/tlne_pkg.sv]
// tlne_pkg: types, constants and codes shared by the line numbering and
// escape formatter. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tlne_pkg;

	localparam int NUMBER_DIGITS = 6;
	localparam int DIGIT_W       = 4 * NUMBER_DIGITS;
	localparam int PREFIX_LEN    = NUMBER_DIGITS + 1;
	localparam int BODY_MAX      = 4;
	localparam int BLEN_W        = $clog2(BODY_MAX + 1);
	localparam int POS_W         = $clog2(PREFIX_LEN + BODY_MAX);
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W     = 3;

	localparam logic [DIGIT_W-1:0] COUNT_ONE = DIGIT_W'(1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANKS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENDS_WITH_VISIBLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENDS_ONLY         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TABS_WITH_VISIBLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TABS_ONLY         = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CARET_ESCAPES     = 3'd7;

	// line prefix kinds
	localparam logic [1:0] PFX_NONE  = 2'd0;
	localparam logic [1:0] PFX_NUM   = 2'd1;
	localparam logic [1:0] PFX_BLANK = 2'd2;

	// characters
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CTRL_OFS  = 8'h40;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic number_nonblank;
		logic number_all;
		logic squeeze_blanks;
		logic ends_with_visible;
		logic ends_only;
		logic tabs_with_visible;
		logic tabs_only;
		logic caret_escapes;
	} cfg_t;

	// one classified input byte, ready for serialising
	typedef struct packed {
		logic [1:0]                pfx;
		logic [DIGIT_W-1:0]        digits;
		logic [BODY_MAX-1:0][7:0]  body;
		logic [BLEN_W-1:0]         blen;
	} desc_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage

[hw/rtl/tlne_front.sv]
// tlne_front: configuration registers, per-file line state and byte
// classification into descriptors. Depends on tlne_pkg.
`timescale 1ns / 1ps
module tlne_front
	import tlne_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 q_full,
	output logic                 q_push,
	output desc_t                q_data
);

	cfg_t               cfg_q;
	logic [DIGIT_W-1:0] count_q;
	logic               at_start_q;
	logic               prev_nl_q;
	logic [1:0]         blank_run_q;

	logic [DIGIT_W-1:0] cnt_e, cnt_inc, cnt_n;
	logic               als_e, pnl_e;
	logic [1:0]         br_e, br_n;
	logic               als_n;
	logic               is_nl, skip, accept, all_nines, carry;
	logic               visible, tab_mark, end_mark;
	logic [7:0]         ch, low;
	logic [3:0]         d;
	desc_t              desc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUMBER_NONBLANK:   cfg_q.number_nonblank   <= cfg_data;
				REG_NUMBER_ALL:        cfg_q.number_all        <= cfg_data;
				REG_SQUEEZE_BLANKS:    cfg_q.squeeze_blanks    <= cfg_data;
				REG_ENDS_WITH_VISIBLE: cfg_q.ends_with_visible <= cfg_data;
				REG_ENDS_ONLY:         cfg_q.ends_only         <= cfg_data;
				REG_TABS_WITH_VISIBLE: cfg_q.tabs_with_visible <= cfg_data;
				REG_TABS_ONLY:         cfg_q.tabs_only         <= cfg_data;
				REG_CARET_ESCAPES:     cfg_q.caret_escapes     <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturating BCD increment
	always_comb begin
		carry     = 1'b1;
		all_nines = 1'b1;
		cnt_inc   = cnt_e;
		for (int k = 0; k < NUMBER_DIGITS; k++) begin
			d = cnt_e[4*k +: 4];
			all_nines = all_nines && (d == 4'd9);
			if (carry) begin
				if (d == 4'd9) begin
					cnt_inc[4*k +: 4] = 4'd0;
				end else begin
					cnt_inc[4*k +: 4] = d + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (all_nines)
			cnt_inc = cnt_e;
	end

	always_comb begin
		ch       = in_data.in_byte;
		low      = {1'b0, ch[6:0]};
		is_nl    = (ch == CH_NL);
		visible  = cfg_q.caret_escapes || cfg_q.tabs_with_visible
			|| cfg_q.ends_with_visible;
		tab_mark = cfg_q.tabs_with_visible || cfg_q.tabs_only;
		end_mark = cfg_q.ends_with_visible || cfg_q.ends_only;

		cnt_e = in_data.file_start ? COUNT_ONE : count_q;
		als_e = in_data.file_start ? 1'b1 : at_start_q;
		pnl_e = in_data.file_start ? 1'b1 : prev_nl_q;
		br_e  = in_data.file_start ? 2'd0 : blank_run_q;

		br_n = br_e;
		skip = 1'b0;
		if (cfg_q.squeeze_blanks) begin
			if (is_nl && pnl_e) begin
				if (br_e < 2'd2)
					br_n = br_e + 2'd1;
				skip = (br_n > 2'd1);
			end else begin
				br_n = 2'd0;
			end
		end

		desc.pfx    = PFX_NONE;
		desc.digits = cnt_e;
		if (cfg_q.number_nonblank) begin
			if (als_e && !is_nl)
				desc.pfx = PFX_NUM;
			else if (als_e && is_nl && end_mark)
				desc.pfx = PFX_BLANK;
		end else if (cfg_q.number_all && als_e) begin
			desc.pfx = PFX_NUM;
		end

		cnt_n = cnt_e;
		als_n = als_e;
		if (!skip) begin
			als_n = is_nl;
			if (desc.pfx == PFX_NUM)
				cnt_n = cnt_inc;
		end

		desc.body = {BODY_MAX{ch}};
		desc.blen = BLEN_W'(1);
		if (ch == CH_TAB) begin
			if (tab_mark) begin
				desc.body[0] = CH_CARET;
				desc.body[1] = CH_I;
				desc.blen    = BLEN_W'(2);
			end
		end else if (is_nl) begin
			if (end_mark) begin
				desc.body[0] = CH_DOLLAR;
				desc.body[1] = CH_NL;
				desc.blen    = BLEN_W'(2);
			end
		end else if (!visible || (ch >= CH_SPACE && ch < CH_DEL)) begin
			desc.body[0] = ch;
		end else if (ch == CH_DEL) begin
			desc.body[0] = CH_CARET;
			desc.body[1] = CH_QUEST;
			desc.blen    = BLEN_W'(2);
		end else if (ch < CH_SPACE) begin
			desc.body[0] = CH_CARET;
			desc.body[1] = ch + CTRL_OFS;
			desc.blen    = BLEN_W'(2);
		end else begin
			desc.body[0] = CH_M;
			desc.body[1] = CH_DASH;
			if (low >= CH_SPACE && low < CH_DEL) begin
				desc.body[2] = low;
				desc.blen    = BLEN_W'(3);
			end else if (low == CH_DEL) begin
				desc.body[2] = CH_CARET;
				desc.body[3] = CH_QUEST;
				desc.blen    = BLEN_W'(4);
			end else begin
				desc.body[2] = CH_CARET;
				desc.body[3] = low + CTRL_OFS;
				desc.blen    = BLEN_W'(4);
			end
		end
	end

	assign q_push = accept && !skip;
	assign q_data = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_ONE;
			at_start_q  <= 1'b1;
			prev_nl_q   <= 1'b1;
			blank_run_q <= 2'd0;
		end else if (accept) begin
			count_q     <= cnt_n;
			at_start_q  <= als_n;
			prev_nl_q   <= is_nl;
			blank_run_q <= br_n;
		end
	end

endmodule

[hw/rtl/tlne_queue.sv]
// tlne_queue: small descriptor FIFO between front and back.
// Depends on tlne_pkg.
`timescale 1ns / 1ps
module tlne_queue
	import tlne_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  qctl_t ctl_in,
	output logic  full,
	input  desc_t wr_data,
	input  logic  pop,
	output logic  head_valid,
	output desc_t head
);

	desc_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = ctl_in.push && !ctl_in.full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (!do_push && do_pop)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

[hw/rtl/tlne_back.sv]
// tlne_back: walks each descriptor one output byte per cycle, while the
// receiver is ready, into a registered output stage. Depends on tlne_pkg.
`timescale 1ns / 1ps
module tlne_back
	import tlne_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  desc_t     head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic [POS_W-1:0]       pos_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic [POS_W-1:0]       pre_len, body_pos, last_pos;
	logic [NUMBER_DIGITS:0] lead;
	logic [7:0]             col_byte, byte_n;
	logic                   load, last;

	// lead[k]: digit k and all above it are zero
	always_comb begin
		lead[NUMBER_DIGITS] = 1'b1;
		for (int k = NUMBER_DIGITS - 1; k >= 0; k--)
			lead[k] = lead[k+1] && (head.digits[4*k +: 4] == 4'd0);
	end

	always_comb begin
		col_byte = CH_SPACE;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (pos_q == POS_W'(i)) begin
				if (head.pfx == PFX_BLANK
					|| (lead[NUMBER_DIGITS-1-i] && i != NUMBER_DIGITS - 1))
					col_byte = CH_SPACE;
				else
					col_byte = CH_ZERO
						+ {4'd0, head.digits[4*(NUMBER_DIGITS-1-i) +: 4]};
			end
		end
	end

	always_comb begin
		pre_len  = (head.pfx != PFX_NONE) ? POS_W'(PREFIX_LEN) : '0;
		body_pos = pos_q - pre_len;
		last_pos = pre_len + POS_W'(head.blen) - POS_W'(1);
		last     = (pos_q == last_pos);
		if (pos_q < pre_len) begin
			if (pos_q == POS_W'(NUMBER_DIGITS))
				byte_n = CH_TAB;
			else
				byte_n = col_byte;
		end else begin
			byte_n = head.body[body_pos[$clog2(BODY_MAX)-1:0]];
		end
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= byte_n;
			out_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pos_q       <= last ? '0 : pos_q + POS_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hw/rtl/text_line_number_and_escape_top.sv]
// text_line_number_and_escape_top: cat-style line numbering and caret
// escaping. Depends on tlne_pkg, tlne_front, tlne_queue, tlne_back.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data) takes one text byte per
//    transaction plus a file_start flag that restarts the line count and
//    line state before that byte.
//  - Output channel (out_valid/out_ready/out_data) gives one formatted byte
//    per transaction; last_of_run marks the final byte an input caused.
//    A squeezed blank line produces nothing.
//  - Configuration: cfg_we writes bit cfg_data to option cfg_index in the
//    same cycle; write only while the block is idle.
//  - Path: the descriptor is written into the queue when the input is
//    taken, and the back end then loads its first output byte into the
//    output register, from which it can leave.
//  - Throughput: one output byte per cycle while the receiver is ready; a
//    numbered line start gives up to 11 output bytes, which the back
//    end serialises one descriptor byte a cycle. The front accepts a new
//    byte each cycle while the four-entry descriptor queue has room.
//  - Receiver stall: the output register holds; the queue fills and then
//    in_ready drops until space frees.
//  - Reset: options cleared, line count back to one, queue and output
//    emptied.
`timescale 1ns / 1ps
module text_line_number_and_escape_top
	import tlne_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	qctl_t qctl;
	desc_t push_desc, head_desc;
	logic  head_valid, pop, q_full, q_push;

	assign qctl.push = q_push;
	assign qctl.full = q_full;

	// classify and track line state
	tlne_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_desc)
	);

	// decouples classification from serialising
	tlne_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_in     (qctl),
		.full       (q_full),
		.wr_data    (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head_desc)
	);

	// one output byte per cycle, while the receiver is ready, into the output register
	tlne_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head_desc),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
